[rtl/core/open_addressing_hash_table_top_defines.svh]
// ----------------------------------------------------------------------------
// open_addressing_hash_table_top_defines
// Assertion macros shared by the hash table RTL. Each macro samples on clk
// and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESSING_HASH_TABLE_TOP_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication: when cond holds, prop must hold too.
`define OAHT_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("hash table assertion failed");

// Next-cycle implication: when cond holds, prop must hold in the next cycle.
`define OAHT_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("hash table assertion failed");

`endif

[rtl/core/oaht_pkg.sv]
// ----------------------------------------------------------------------------
// oaht_pkg
// Widths, codes and shared types of the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    // Default number of key slots
    localparam int SLOT_COUNT_DEF = 10;

    // Field widths
    localparam int KEY_W      = 16;
    localparam int SLOT_IDX_W = 6;
    localparam int STATUS_W   = 2;

    // Modulus of the secondary hash step
    localparam int STEP_MOD = 7;

    // Actions
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // Probe modes
    localparam logic MODE_DOUBLE    = 1'b0;
    localparam logic MODE_QUADRATIC = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Home slot and double-hashing step, both already reduced mod slot count
    typedef struct packed {
        logic [SLOT_IDX_W-1:0] home;
        logic [SLOT_IDX_W-1:0] step;
    } hash_t;

endpackage

[rtl/core/oaht_req_if.sv]
// ----------------------------------------------------------------------------
// oaht_req_if
// Request channel: one beat carries an action and a key.
// ----------------------------------------------------------------------------
interface oaht_req_if import oaht_pkg::*; ();

    logic             valid;
    logic             ready;
    logic             action;
    logic [KEY_W-1:0] key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);

endinterface

[rtl/core/oaht_rsp_if.sv]
// ----------------------------------------------------------------------------
// oaht_rsp_if
// Response channel: one beat carries a status and a slot index.
// ----------------------------------------------------------------------------
interface oaht_rsp_if import oaht_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink   (input valid, input status, input slot_index, output ready);

endinterface

[rtl/core/oaht_cfg_if.sv]
// ----------------------------------------------------------------------------
// oaht_cfg_if
// Configuration write channel: one beat writes the probe mode register.
// ----------------------------------------------------------------------------
interface oaht_cfg_if import oaht_pkg::*; ();

    logic valid;
    logic ready;
    logic probe_mode;

    modport source (output valid, output probe_mode, input ready);
    modport sink   (input valid, input probe_mode, output ready);

endinterface

[rtl/core/oaht_hash.sv]
// ----------------------------------------------------------------------------
// oaht_hash
// Two-stage hash unit: home slot (key mod slot count, by reciprocal multiply
// with one correction) and secondary step (7 - key mod 7), reduced mod slots.
// ----------------------------------------------------------------------------
module oaht_hash
    import oaht_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             hash_valid,
    output hash_t            hash
);

    localparam int          PROD_W = KEY_W + 32;
    localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / SLOT_COUNT);
    localparam int          QN_W   = KEY_W + 7;

    logic              v1_reg;
    logic              v2_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [5:0]        dsum_reg;
    hash_t             hash_reg;
    hash_t             hash_next;

    logic [KEY_W-1:0]  quot;
    logic [QN_W-1:0]   qn;
    logic [KEY_W:0]    rem0;
    logic [KEY_W:0]    home_full;
    logic [3:0]        fold;
    logic [3:0]        r7;
    logic [7:0]        step_red;
    logic [5:0]        dsum;

    // Sum octal digits: 8 is 1 mod 7, so the sum keeps the residue
    assign dsum = 6'(key[2:0]) + 6'(key[5:3]) + 6'(key[8:6]) + 6'(key[11:9])
                + 6'(key[14:12]) + 6'(key[15]);

    // Stage one: reciprocal product and digit sum
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PROD_W'(key) * PROD_W'(RECIP);
            key_reg  <= key;
            dsum_reg <= dsum;
        end
    end

    // Stage two: correct the remainder, finish mod 7, reduce the step
    always_comb
    begin
        quot      = prod_reg[PROD_W-1:32];
        qn        = QN_W'(quot) * QN_W'(SLOT_COUNT);
        rem0      = (KEY_W+1)'(key_reg) - (KEY_W+1)'(qn);
        home_full = (rem0 >= (KEY_W+1)'(SLOT_COUNT)) ? rem0 - (KEY_W+1)'(SLOT_COUNT) : rem0;

        fold = 4'(dsum_reg[5:3]) + 4'(dsum_reg[2:0]);
        if (fold >= 4'(2 * STEP_MOD))
            r7 = fold - 4'(2 * STEP_MOD);
        else if (fold >= 4'(STEP_MOD))
            r7 = fold - 4'(STEP_MOD);
        else
            r7 = fold;

        // Step is 1..7, below four times any slot count of two or more
        step_red = 8'(4'(STEP_MOD) - r7);
        for (int n = 0; n < 3; n++)
        begin
            if (step_red >= 8'(SLOT_COUNT))
                step_red = step_red - 8'(SLOT_COUNT);
        end

        hash_next.home = home_full[SLOT_IDX_W-1:0];
        hash_next.step = step_red[SLOT_IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
            hash_reg <= hash_next;
    end

    // Track stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    assign hash_valid = v2_reg;
    assign hash       = hash_reg;

endmodule

[rtl/core/open_addressing_hash_table_top.sv]
// Sequencing: an item is hashed by the two-stage hash unit, then probed until a
// hit or SLOT_COUNT probes, then reported. The next request is taken in the
// cycle in which the response beat is presented; no new request enters while an
// item is in flight. The key memory read port serves one probe per cycle.
// Reset: asynchronous active-low; clears all slot valid bits (table empty) at
// once, probe mode to double hashing, no clearing pass.
// ----------------------------------------------------------------------------
// open_addressing_hash_table_top
// Open-addressing hash table with double-hashing or quadratic probing. Keys
// live in a synchronous memory; one probe read is issued per cycle while the
// previous probe is compared.
// ----------------------------------------------------------------------------
`include "open_addressing_hash_table_top_defines.svh"

module open_addressing_hash_table_top
    import oaht_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input logic         clk,
    input logic         rst_n,
    oaht_req_if.sink    req,
    oaht_rsp_if.source  rsp,
    oaht_cfg_if.sink    cfg
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_HASH  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic                  mode_reg;
    logic                  action_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     step_reg;
    logic [SLOT_W-1:0]     delta_reg;
    logic [CNT_W-1:0]      issue_cnt_reg;
    logic                  chk_pend_reg;
    logic [SLOT_W-1:0]     chk_slot_reg;
    logic [KEY_W-1:0]      rd_data_reg;
    logic                  rd_valid_reg;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [SLOT_IDX_W-1:0] res_slot_reg;
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [SLOT_IDX_W-1:0] out_slot_reg;

    logic [KEY_W-1:0]      key_mem [SLOT_COUNT];

    logic                  accept;
    logic                  hash_valid;
    hash_t                 hash;
    logic                  issue;
    logic [KEY_W-1:0]      eff_key;
    logic                  hit;
    logic                  last;
    logic                  wr_en;
    logic                  out_load;
    logic                  res_miss;
    logic [SLOT_W-1:0]     inc;
    logic [SLOT_W:0]       slot_sum;
    logic [SLOT_W-1:0]     slot_next;
    logic [SLOT_W:0]       delta_sum;
    logic [SLOT_W-1:0]     delta_next;

    oaht_hash #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .key        (req.key),
        .hash_valid (hash_valid),
        .hash       (hash)
    );

    // Handshakes
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // Probe address stepping: fixed step, or odd increments for i*i
    always_comb
    begin
        inc        = (mode_reg == MODE_QUADRATIC) ? delta_reg : step_reg;
        slot_sum   = {1'b0, slot_reg} + {1'b0, inc};
        slot_next  = (slot_sum >= (SLOT_W+1)'(SLOT_COUNT))
                   ? SLOT_W'(slot_sum - (SLOT_W+1)'(SLOT_COUNT)) : SLOT_W'(slot_sum);
        delta_sum  = {1'b0, delta_reg} + (SLOT_W+1)'(2);
        delta_next = (delta_sum >= (SLOT_W+1)'(SLOT_COUNT))
                   ? SLOT_W'(delta_sum - (SLOT_W+1)'(SLOT_COUNT)) : SLOT_W'(delta_sum);
    end

    // Compare the probe whose read data has arrived
    always_comb
    begin
        issue   = (state_reg == S_PROBE) && (issue_cnt_reg != CNT_W'(SLOT_COUNT));
        eff_key = rd_valid_reg ? rd_data_reg : '0;
        if (action_reg == ACT_INSERT)
            hit = (state_reg == S_PROBE) && chk_pend_reg && (eff_key == '0);
        else
            hit = (state_reg == S_PROBE) && chk_pend_reg && (eff_key == key_reg);
        last     = (state_reg == S_PROBE) && chk_pend_reg
                && (issue_cnt_reg == CNT_W'(SLOT_COUNT));
        wr_en    = hit && (action_reg == ACT_INSERT);
        out_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);
    end

    // Sequence one item: hash, probe, report
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_HASH;
            end
            S_HASH:
            begin
                if (hash_valid)
                    state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (hit || last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_DOUBLE;
        else if (cfg.valid && cfg.ready)
            mode_reg <= cfg.probe_mode;
    end

    // Capture the request beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= req.action;
            key_reg    <= req.key;
        end
    end

    // Probe walker: load the home slot, then advance one probe per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
            chk_pend_reg  <= 1'b0;
        end
        else if ((state_reg == S_HASH) && hash_valid)
        begin
            issue_cnt_reg <= '0;
            chk_pend_reg  <= 1'b0;
        end
        else if (hit || last)
        begin
            chk_pend_reg <= 1'b0;
        end
        else if (issue)
        begin
            issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            chk_pend_reg  <= 1'b1;
        end
        else
        begin
            chk_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_HASH) && hash_valid)
        begin
            slot_reg  <= hash.home[SLOT_W-1:0];
            step_reg  <= hash.step[SLOT_W-1:0];
            delta_reg <= SLOT_W'(1);
        end
        else if (issue)
        begin
            slot_reg     <= slot_next;
            delta_reg    <= delta_next;
            chk_slot_reg <= slot_reg;
        end
    end

    // Key memory: write on insert hit, read the issued probe
    always_ff @(posedge clk)
    begin
        if (wr_en)
            key_mem[chk_slot_reg] <= key_reg;
        if (issue)
            rd_data_reg <= key_mem[slot_reg];
    end

    // Slot valid bits: an invalid slot reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[chk_slot_reg] <= 1'b1;
            if (issue)
                rd_valid_reg <= valid_reg[slot_reg];
        end
    end

    // Latch the result of the item
    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            res_status_reg <= (action_reg == ACT_INSERT) ? ST_INSERTED : ST_FOUND;
            res_slot_reg   <= SLOT_IDX_W'(chk_slot_reg);
        end
        else if (last)
        begin
            res_status_reg <= (action_reg == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
            res_slot_reg   <= '0;
        end
    end

    // Output register: holds a beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.slot_index = out_slot_reg;

    // Flag a result that reports no slot
    assign res_miss = (res_status_reg == ST_FULL) || (res_status_reg == ST_NOT_FOUND);

    // Checks
    `OAHT_ASSERT_NEXT(a_accept_starts_hash, accept, state_reg == S_HASH)
    `OAHT_ASSERT_NEXT(a_write_marks_valid, wr_en, valid_reg[$past(chk_slot_reg)])
    `OAHT_ASSERT_NOW(a_probe_count_bound, state_reg == S_PROBE, issue_cnt_reg <= CNT_W'(SLOT_COUNT))
    `OAHT_ASSERT_NOW(a_miss_slot_zero, out_load && res_miss, res_slot_reg == '0)

endmodule
